// ===== sv/double_layer_potential_sum_assert.svh =====
// Assertion macros for the double-layer potential block.
// Used by the front, back and top level files; no other dependencies.
`ifndef DOUBLE_LAYER_POTENTIAL_SUM_ASSERT_SVH
`define DOUBLE_LAYER_POTENTIAL_SUM_ASSERT_SVH
`ifndef SYNTH
`define DLP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define DLP_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DLP_ASSERT(label, clk, rst, prop)
`define DLP_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== sv/dlps_pkg.sv =====
// Shared types and constants for the double-layer potential block.
// No dependencies.
package dlps_pkg;
  localparam int NUM_W = 128;
  localparam int SQ_W  = 67;
  localparam int DEN_W = 102;
  // |density| * |d . n| needs up to 32 + 54 bits
  localparam int MAG_W = 86;

  // word passed from the front part to the back part
  typedef struct packed {
    logic                    skip;
    logic                    neg;
    logic                    last;
    logic [SQ_W-1:0]         s;
    logic [MAG_W-1:0]        mag;
  } job_t;

  // status from back part to top
  typedef struct packed {
    logic busy;
    logic done;
  } back_stat_t;
endpackage

// ===== sv/dlps_front.sv =====
// Front part: forms offsets, squared distance, dot product and cutoff class.
// Depends on dlps_pkg. Takes a new word only in IDLE, once the last is handed off.
`include "double_layer_potential_sum_assert.svh"
module dlps_front
  import dlps_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        cutoff_sq,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] target_x, target_y, target_z,
  input  logic signed [31:0] source_x, source_y, source_z,
  input  logic signed [17:0] normal_x, normal_y, normal_z,
  input  logic signed [31:0] density,
  input  logic               last_source,
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job
);
  typedef enum logic [2:0] {IDLE, AXIS, PLO, PHI, OUT} state_t;
  state_t state;
  logic [1:0] axis;
  logic signed [32:0] d [3];
  logic signed [17:0] n [3];
  logic signed [31:0] p;
  logic last;
  logic [SQ_W-1:0] s;
  logic signed [53:0] dot;
  logic [MAG_W-1:0] mag;
  logic neg;
  logic signed [32:0] da;
  logic signed [17:0] na;
  logic [32:0] ua;
  logic [31:0] up;
  logic [53:0] udot;
  logic [SQ_W-1:0] lim;

  assign da = d[axis];
  assign na = n[axis];
  assign ua = da[32] ? 33'(-da) : 33'(da);
  assign up = p[31] ? 32'(-p) : 32'(p);
  assign udot = dot[53] ? 54'(-dot) : 54'(dot);
  assign lim = SQ_W'({32'b0, cutoff_sq} << FRAC_BITS);
  assign in_ready = (state == IDLE);
  assign job_valid = (state == OUT);

  // one axis per cycle: square and dot term
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      axis <= '0;
    end else begin
      case (state)
        IDLE: if (in_valid) begin
          d[0] <= 33'(target_x) - 33'(source_x);
          d[1] <= 33'(target_y) - 33'(source_y);
          d[2] <= 33'(target_z) - 33'(source_z);
          n[0] <= normal_x; n[1] <= normal_y; n[2] <= normal_z;
          p <= density;
          last <= last_source;
          s <= '0;
          dot <= '0;
          axis <= '0;
          state <= AXIS;
        end
        AXIS: begin
          s <= s + SQ_W'(ua * ua);
          dot <= dot + 54'(da * na);
          if (axis == 2'd2) state <= PLO;
          else axis <= axis + 2'd1;
        end
        // 32 x 54 product in two 32 x 27 halves
        PLO: begin
          mag <= MAG_W'(up * udot[26:0]);
          neg <= p[31] ^ dot[53];
          state <= PHI;
        end
        PHI: begin
          mag <= mag + (MAG_W'(up * udot[53:27]) << 27);
          state <= OUT;
        end
        OUT: if (job_ready) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  assign job.skip = (s <= lim);
  assign job.neg  = neg;
  assign job.last = last;
  assign job.s    = s;
  assign job.mag  = mag;

  `DLP_ASSERT(a_front_hold, clk, rst, job_valid && !job_ready |=> job_valid)
endmodule

// ===== sv/dlps_back.sv =====
// Back part: integer square root, multiply, restoring divide and saturating sum.
// Depends on dlps_pkg. One root or quotient bit per cycle.
`include "double_layer_potential_sum_assert.svh"
module dlps_back
  import dlps_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [63:0] res,
  output back_stat_t  stat
);
  typedef enum logic [2:0] {IDLE, ROOT, DMUL, DIV, ADD, EMIT} state_t;
  localparam int SH = FRAC_BITS + 16;
  localparam int SP_W = 17;
  state_t state;
  job_t cur;
  logic [5:0] bitn;
  logic [6:0] cnt;
  logic [33:0] q;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0] rem;
  logic signed [63:0] sum;
  logic signed [63:0] term;
  logic [33:0] qt;
  logic [67:0] qsq;
  logic [DEN_W:0] rsh;
  logic signed [64:0] wsum;
  logic [4*SP_W-1:0] s_ext;
  logic [SP_W-1:0] spart;

  assign qt  = q | (34'd1 << bitn);
  assign qsq = qt * qt;
  assign rsh = {rem[DEN_W-1:0], num[NUM_W-1]};
  assign wsum = 65'(sum) + 65'(term);
  assign s_ext = {1'b0, cur.s};
  assign spart = s_ext[cnt[1:0]*SP_W +: SP_W];
  assign job_ready = (state == IDLE);
  assign res_valid = (state == EMIT);
  assign res = sum;
  assign stat.busy = (state != IDLE);
  assign stat.done = (state == EMIT) && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      sum <= '0;
    end else begin
      case (state)
        IDLE: if (job_valid) begin
          cur <= job;
          q <= '0;
          bitn <= 6'd33;
          if (job.skip) begin
            term <= '0;
            state <= ADD;
          end else state <= ROOT;
        end
        // one root bit per cycle
        ROOT: begin
          if ({1'b0, qsq} <= 69'(cur.s)) q <= qt;
          if (bitn == 6'd0) begin
            den <= '0;
            cnt <= 7'd3;
            state <= DMUL;
          end else bitn <= bitn - 6'd1;
        end
        // s * root, one 17-bit slice of s per cycle, top slice first
        DMUL: begin
          den <= (den << SP_W) + DEN_W'(spart * q);
          if (cnt == 7'd0) begin
            num <= NUM_W'(cur.mag) << SH;
            rem <= '0;
            quo <= '0;
            cnt <= 7'(NUM_W - 1);
            state <= DIV;
          end else cnt <= cnt - 7'd1;
        end
        // one quotient bit per cycle
        DIV: begin
          if (rsh >= {1'b0, den}) begin
            rem <= rsh - {1'b0, den};
            quo <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            rem <= rsh;
            quo <= {quo[NUM_W-2:0], 1'b0};
          end
          num <= num << 1;
          if (cnt == 7'd0) state <= ADD;
          else cnt <= cnt - 7'd1;
        end
        ADD: begin
          if (cur.skip) term <= '0;
          // saturate quotient then sum
          if (!cur.skip) begin
            if (cur.neg) begin
              if (quo[NUM_W-1:63] != '0) term <= 64'sh8000000000000000;
              else term <= -$signed(quo[63:0]);
            end else begin
              if (quo[NUM_W-1:63] != '0) term <= 64'sh7FFFFFFFFFFFFFFF;
              else term <= $signed(quo[63:0]);
            end
            cur.skip <= 1'b1;
          end else begin
            if (wsum[64] != wsum[63])
              sum <= wsum[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
            else sum <= wsum[63:0];
            state <= cur.last ? EMIT : IDLE;
          end
        end
        EMIT: if (res_ready) begin
          sum <= '0;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  `DLP_ASSERT(a_emit_clear, clk, rst, res_valid && res_ready |=> sum == 0)
  `DLP_ASSERT(a_emit_hold, clk, rst, res_valid && !res_ready |=> $stable(res))
endmodule

// ===== sv/double_layer_potential_sum.sv =====
// Double-layer potential sum: words pair a target with a source point; the
// front takes each word through accept, 3 axis steps, 2 product steps and
// hand off; a two-entry queue feeds the back, taking each source through a
// 34-step root, 4-step multiply and 128-step divide; skipped sources omit them.
// The last source emits the Q32.32 sum. Depends on dlps_pkg, front, back.
`include "double_layer_potential_sum_assert.svh"
module double_layer_potential_sum
  import dlps_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cutoff_sq_we,
  input  logic [31:0]        cutoff_sq_wdata,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] target_x, target_y, target_z,
  input  logic signed [31:0] source_x, source_y, source_z,
  input  logic signed [17:0] normal_x, normal_y, normal_z,
  input  logic signed [31:0] density,
  input  logic               last_source,
  output logic               empty,
  input  logic               pop,
  output logic signed [63:0] potential
);
  logic [31:0] cutoff_sq;
  logic in_ready, fj_valid, fj_ready, bj_valid, bj_ready, res_valid;
  job_t fj, bj;
  job_t qm [2];
  logic [1:0] cnt;
  logic rp, wp;
  logic [63:0] res;
  back_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) cutoff_sq <= '0;
    else if (cutoff_sq_we) cutoff_sq <= cutoff_sq_wdata;
  end

  assign full = !in_ready;

  dlps_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .cutoff_sq, .in_valid(push), .in_ready,
    .target_x, .target_y, .target_z, .source_x, .source_y, .source_z,
    .normal_x, .normal_y, .normal_z, .density, .last_source,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  // two-entry queue between front and back
  assign fj_ready = (cnt != 2'd2);
  assign bj_valid = (cnt != 2'd0);
  assign bj = qm[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rp <= 1'b0; wp <= 1'b0;
    end else begin
      if (fj_valid && fj_ready) begin
        qm[wp] <= fj;
        wp <= ~wp;
      end
      if (bj_valid && bj_ready) rp <= ~rp;
      cnt <= cnt + 2'(fj_valid && fj_ready) - 2'(bj_valid && bj_ready);
    end
  end

  dlps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .res_valid, .res_ready(pop), .res, .stat
  );

  assign empty = !res_valid;
  assign potential = $signed(res);

  `DLP_ASSERT(a_q_bound, clk, rst, cnt <= 2'd2)
  `DLP_ASSERT(a_pop_busy, clk, rst, stat.done |-> stat.busy)
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_layer_potential_sum: drives source words,
// predicts each target's Q32.32 sum and checks every popped result against it.
// Depends only on the double_layer_potential_sum RTL.
module testbench;
  localparam int FRAC = 16;
  localparam int NORM_FRAC = 16;
  localparam longint CYCLE_LIMIT = 3000000;
  // worst back-end time for two queued words plus the front pipeline
  localparam int DRAIN_CYCLES = 400;
  localparam logic signed [63:0] SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic signed [31:0] tx, ty, tz;
    logic signed [31:0] sx, sy, sz;
    logic signed [17:0] nx, ny, nz;
    logic signed [31:0] dens;
    logic               last;
  } source_word_t;

  logic               clk;
  logic               rst;
  logic               cutoff_sq_we;
  logic [31:0]        cutoff_sq_wdata;
  logic               push;
  logic               full;
  logic signed [31:0] target_x, target_y, target_z;
  logic signed [31:0] source_x, source_y, source_z;
  logic signed [17:0] normal_x, normal_y, normal_z;
  logic signed [31:0] density;
  logic               last_source;
  logic               empty;
  logic               pop;
  logic signed [63:0] potential;

  // predictor state
  logic [31:0]        model_cutoff;
  logic signed [63:0] model_sum;
  logic signed [63:0] pending_sums[$];

  int     fail_count;
  longint cycle_count;
  int     pop_hold;      // receiver hold-off request, in cycles
  bit     send_no_gaps;
  bit     pop_no_gaps;

  double_layer_potential_sum #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .cutoff_sq_we(cutoff_sq_we), .cutoff_sq_wdata(cutoff_sq_wdata),
    .push(push), .full(full),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .source_x(source_x), .source_y(source_y), .source_z(source_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .density(density), .last_source(last_source),
    .empty(empty), .pop(pop), .potential(potential)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // one source's contribution: density * (d . n) / R^3, saturated
  function automatic logic signed [63:0] source_term(source_word_t w);
    logic signed [63:0] d[3];
    logic signed [63:0] n[3];
    logic signed [63:0] dot;
    logic [63:0]        mag_d, mag_p, root, trial;
    logic [127:0]       sq_sum, lim, num, den, quo;
    bit                 neg;
    d[0] = 64'(w.tx) - 64'(w.sx);
    d[1] = 64'(w.ty) - 64'(w.sy);
    d[2] = 64'(w.tz) - 64'(w.sz);
    n[0] = 64'(w.nx);
    n[1] = 64'(w.ny);
    n[2] = 64'(w.nz);
    sq_sum = '0;
    dot = '0;
    for (int k = 0; k < 3; k++) begin
      mag_d = d[k] < 0 ? -d[k] : d[k];
      sq_sum += 128'(mag_d) * 128'(mag_d);
      dot += d[k] * n[k];
    end
    lim = 128'(model_cutoff) << FRAC;
    if (lim >= sq_sum) return '0;
    neg = (w.dens < 0) != (dot < 0);
    mag_p = w.dens < 0 ? -64'(w.dens) : 64'(w.dens);
    mag_d = dot < 0 ? -dot : dot;
    num = (128'(mag_p) * 128'(mag_d)) << (FRAC + NORM_FRAC);
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= sq_sum) root = trial;
    end
    den = sq_sum * 128'(root);
    quo = num / den;
    if (neg) begin
      if (quo >= (128'd1 << 63)) return SUM_MIN;
      return -$signed(quo[63:0]);
    end
    if (quo > 128'(SUM_MAX)) return SUM_MAX;
    return $signed(quo[63:0]);
  endfunction

  // accumulate one accepted word; a last word queues the expected sum
  function automatic void accumulate_source(source_word_t w);
    logic signed [64:0] wide;
    wide = 65'(model_sum) + 65'(source_term(w));
    if (wide > 65'(SUM_MAX)) model_sum = SUM_MAX;
    else if (wide < 65'(SUM_MIN)) model_sum = SUM_MIN;
    else model_sum = wide[63:0];
    if (w.last) begin
      pending_sums.push_back(model_sum);
      model_sum = '0;
    end
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one word until accepted, then maybe idle
  task automatic send_word(source_word_t w);
    int gap;
    push = 1'b1;
    target_x = w.tx; target_y = w.ty; target_z = w.tz;
    source_x = w.sx; source_y = w.sy; source_z = w.sz;
    normal_x = w.nx; normal_y = w.ny; normal_z = w.nz;
    density = w.dens;
    last_source = w.last;
    @(posedge clk);
    while (full) @(posedge clk);
    accumulate_source(w);
    @(negedge clk);
    gap = send_no_gaps ? 0 : gap_length();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_cutoff(logic [31:0] value);
    cutoff_sq_we = 1'b1;
    cutoff_sq_wdata = value;
    model_cutoff = value;
    @(negedge clk);
    cutoff_sq_we = 1'b0;
  endtask

  // block is idle only once all sums are out and the back end has drained
  task automatic wait_idle();
    push = 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic source_word_t make_word(logic signed [31:0] tx, ty, tz, sx, sy, sz,
                                             logic signed [17:0] nx, ny, nz,
                                             logic signed [31:0] dens, logic last);
    source_word_t w;
    w.tx = tx; w.ty = ty; w.tz = tz;
    w.sx = sx; w.sy = sy; w.sz = sz;
    w.nx = nx; w.ny = ny; w.nz = nz;
    w.dens = dens; w.last = last;
    return w;
  endfunction

  function automatic logic signed [31:0] rand_coord(int span);
    if (span >= 31) return $signed(32'($urandom()));
    return $signed(32'($urandom_range(0, (1 << (span + 1)) - 1))) - (32'sd1 <<< span);
  endfunction

  function automatic logic signed [17:0] rand_normal();
    if ($urandom_range(0, 9) == 0) return $signed(18'($urandom()));
    return $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
  endfunction

  // mostly near-field geometry so terms stay in range, some full-range words
  function automatic source_word_t rand_word(logic last);
    source_word_t w;
    int span;
    span = ($urandom_range(0, 7) == 0) ? 31 : $urandom_range(4, 22);
    w.tx = rand_coord(span); w.ty = rand_coord(span); w.tz = rand_coord(span);
    w.sx = rand_coord(span); w.sy = rand_coord(span); w.sz = rand_coord(span);
    w.nx = rand_normal(); w.ny = rand_normal(); w.nz = rand_normal();
    w.dens = ($urandom_range(0, 3) == 0) ? $signed(32'($urandom())) : rand_coord(18);
    w.last = last;
    return w;
  endfunction

  task automatic send_runs(int word_total, int max_run);
    int run_len;
    int sent;
    sent = 0;
    while (sent < word_total) begin
      run_len = $urandom_range(1, max_run);
      for (int i = 0; i < run_len; i++) send_word(rand_word(i == run_len - 1));
      sent += run_len;
    end
  endtask

  // extremes, skipped sources, saturation of term and sum, odd normals
  task automatic test_directed();
    send_word(make_word(0, 0, 0, 0, 0, 0, 18'sd65536, 0, 0, 32'sd65536, 1'b1));
    send_word(make_word(32'sd65536, 0, 0, 0, 0, 0, 18'sd65536, 0, 0, 32'sd65536, 1'b1));
    send_word(make_word(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh80000000, 32'sh80000000, 32'sh80000000,
                        18'sd65536, 18'sd65536, 18'sd65536, 32'sh7fffffff, 1'b1));
    send_word(make_word(32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        -18'sd65536, -18'sd65536, -18'sd65536, 32'sh80000000, 1'b1));
    send_word(make_word(32'sd65536, 0, 0, 0, 0, 0, 0, 18'sd65536, 0, 32'sd1000, 1'b1));
    send_word(make_word(1, 0, 0, 0, 0, 0, 18'sd65536, 0, 0, 32'sh7fffffff, 1'b1));
    send_word(make_word(1, 0, 0, 0, 0, 0, 18'sd65536, 0, 0, 32'sh80000000, 1'b1));
    for (int i = 0; i < 3; i++)
      send_word(make_word(0, 3, 0, 0, 0, 0, 0, 18'sd65536, 0, 32'sh7fffffff, i == 2));
    for (int i = 0; i < 3; i++)
      send_word(make_word(0, 0, 5, 0, 0, 0, 0, 0, 18'sd65536, 32'sh80000000, i == 2));
    send_word(make_word(32'sd131072, 32'sd65536, 0, 0, 0, 0,
                        18'sh1ffff, 18'sh20000, 18'sh1ffff, 32'sd65536, 1'b0));
    send_word(make_word(32'sd65536, 0, 32'sd65536, 0, 0, 0,
                        -18'sd131072, 18'sd131071, 0, -32'sd65536, 1'b0));
    send_word(make_word(-32'sd200000, 32'sd5, 32'sd70000, 32'sd9, -32'sd1, 0,
                        18'sd40000, -18'sd30000, 18'sd20000, 32'sd300000, 1'b1));
    wait_idle();
  endtask

  // cutoff zero, small values far below two known squared distances, and the maximum
  task automatic test_cutoff();
    logic [31:0] cutoffs[5];
    cutoffs = '{32'd0, 32'd3, 32'd4, 32'd5, 32'hffffffff};
    foreach (cutoffs[i]) begin
      write_cutoff(cutoffs[i]);
      send_word(make_word(32'sd131072, 0, 0, 0, 0, 0, 18'sd65536, 0, 0, 32'sd65536, 1'b0));
      send_word(make_word(0, 32'sd65536, 32'sd65536, 0, 0, 0, 0, 18'sd65536, 18'sd65536,
                          32'sd65536, 1'b1));
      send_runs(20, 4);
      wait_idle();
    end
    write_cutoff(32'd0);
  endtask

  // random runs under several cutoffs, with and without idling
  task automatic test_random();
    write_cutoff($urandom_range(0, 255));
    send_runs(300, 6);
    wait_idle();
    write_cutoff($urandom());
    send_runs(100, 6);
    wait_idle();
    write_cutoff(32'd0);
    send_no_gaps = 1'b1;
    pop_no_gaps = 1'b1;
    send_runs(250, 3);
    wait_idle();
    send_no_gaps = 1'b0;
    pop_no_gaps = 1'b0;
    send_runs(200, 8);
    wait_idle();
  endtask

  // receiver stops while single-source runs keep coming, so full must rise
  task automatic test_backpressure();
    pop_hold = 3000;
    send_no_gaps = 1'b1;
    send_runs(40, 1);
    send_no_gaps = 1'b0;
    wait_idle();
  endtask

  // receiver side: pop decided at the falling edge
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop = 1'b0;
        pop_hold--;
      end else if (pop_no_gaps) begin
        pop = 1'b1;
      end else begin
        pop = (gap_length() == 0);
      end
    end
  end

  // result check at the rising edge
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected potential word: %0d", potential);
        fail_count++;
      end else begin
        if (potential !== pending_sums[0]) begin
          $error("potential: expected %0d, actual %0d", pending_sums[0], potential);
          fail_count++;
        end
        void'(pending_sums.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_layer_potential_sum: mismatch");
      $finish;
    end
  end

  initial begin
    fail_count = 0;
    cycle_count = 0;
    pop_hold = 0;
    send_no_gaps = 1'b0;
    pop_no_gaps = 1'b0;
    model_cutoff = '0;
    model_sum = '0;
    rst = 1'b1;
    cutoff_sq_we = 1'b0;
    cutoff_sq_wdata = '0;
    push = 1'b0;
    target_x = '0; target_y = '0; target_z = '0;
    source_x = '0; source_y = '0; source_z = '0;
    normal_x = '0; normal_y = '0; normal_z = '0;
    density = '0;
    last_source = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_cutoff();
    test_random();
    test_backpressure();
    if (pending_sums.size() != 0) begin
      $error("%0d expected potential words never arrived", pending_sums.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("double_layer_potential_sum: match");
    end else begin
      $display("double_layer_potential_sum: mismatch");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/dlps_pkg.sv
sv/dlps_front.sv
sv/dlps_back.sv
sv/double_layer_potential_sum.sv
test/testbench.sv
